// ===== rtl/core/dsf_pkg.sv =====
// ----------------------------------------------------------------------------
// dsf_pkg
// shared widths, codes and polynomial constants of the dynamic smoothing filter
// ----------------------------------------------------------------------------
package dsf_pkg;

  localparam int DSF_CHANNELS  = 8;

  localparam int SAMPLE_W      = 24;
  localparam int STATE_W       = 32;
  localparam int COEF_W        = 24;
  localparam int CH_W          = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int TDATA_W       = 32;
  localparam int ENTRY_W       = 2 * STATE_W + SAMPLE_W;

  // operand widths of the shared multiplier
  localparam int MA_W          = 34;
  localparam int MB_W          = 26;
  localparam int PROD_W        = MA_W + MB_W;

  // input op codes (carried in tuser)
  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_CLEAR    = 1'b1;

  // gain modes
  localparam logic MODE_ACCURATE  = 1'b0;
  localparam logic MODE_EFFICIENT = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_CUTOFF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SLOPE  = 3'd4;

  // register reset values
  localparam logic [COEF_W-1:0] RST_BASE_CUTOFF = 24'd4392;
  localparam logic [COEF_W-1:0] RST_SENSITIVITY = 24'd2097152;
  localparam logic [COEF_W-1:0] RST_BASE_GAIN   = 24'd27597;
  localparam logic [COEF_W-1:0] RST_GAIN_SLOPE  = 24'd2097152;

  // unity gain in q1.24 and cubic coefficients in q.24
  localparam logic [24:0]          ONE_Q24  = 25'd16777216;
  localparam logic signed [MA_W-1:0] CUBIC_C1 = 34'sd100577442;
  localparam logic signed [MA_W-1:0] CUBIC_C2 = -34'sd200811464;
  localparam logic signed [MA_W-1:0] CUBIC_C3 = 34'sd267748630;

  typedef logic [ENTRY_W-1:0] entry_t;

endpackage

// ===== rtl/core/dsf_ram.sv =====
// ----------------------------------------------------------------------------
// dsf_ram
// generic single-clock ram, one write port and one read port, registered read
// ----------------------------------------------------------------------------
module dsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/dynamic_smoothing_filter.sv =====
// ----------------------------------------------------------------------------
// dynamic_smoothing_filter
// multichannel adaptive two-stage one-pole smoother with a shared multiplier
// ----------------------------------------------------------------------------
// channel   dir  signals                         content
// s_*       in   tvalid tready tdata tuser       channel, sample_in / op
// m_*       out  tvalid tready tdata             sample_out
// cfg_*     in   we index wdata                  mode and gain coefficients
//
// one transaction at a time, paced by the single 34x26 multiplier,
// which is used three times (efficient) or six times (accurate) with
// a register stage after each product.
// channel state lives in one ram with per-channel valid flops; reset and
// clear drop the valid flops at once, so there is no clearing pass.
// a result waiting in the output register stalls only the next write-back.
// ----------------------------------------------------------------------------
module dynamic_smoothing_filter
  import dsf_pkg::*;
#(
  parameter int CHANNELS = DSF_CHANNELS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [TDATA_W-1:0]   s_tdata_i,   // [2:0] channel, [26:3] sample_in
  input  logic                 s_tuser_i,   // [0] op
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output logic [SAMPLE_W-1:0]  m_tdata_o,   // [23:0] sample_out
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COEF_W-1:0]    cfg_wdata_i
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL_INC,
    ST_POST_INC,
    ST_MUL_C3,
    ST_POST_C3,
    ST_MUL_C2,
    ST_POST_C2,
    ST_MUL_C1,
    ST_POST_C1,
    ST_MUL_ONE,
    ST_POST_ONE,
    ST_MUL_TWO,
    ST_DONE
  } state_e;

  state_e state_q;

  logic              mode_q;
  logic [COEF_W-1:0] base_cutoff_q;
  logic [COEF_W-1:0] sensitivity_q;
  logic [COEF_W-1:0] base_gain_q;
  logic [COEF_W-1:0] gain_slope_q;

  logic [CHANNELS-1:0]         valid_q;
  logic [AW-1:0]               ch_q;
  logic signed [SAMPLE_W-1:0]  x_q;
  logic signed [SAMPLE_W-1:0]  prev_q;
  logic signed [STATE_W-1:0]   one_q;
  logic signed [STATE_W-1:0]   two_q;
  logic signed [STATE_W-1:0]   new_one_q;
  logic signed [MA_W-1:0]      ma_q;
  logic signed [MB_W-1:0]      mb_q;
  logic signed [PROD_W-1:0]    p_q;
  logic                        m_tvalid_q;
  logic [SAMPLE_W-1:0]         m_tdata_q;

  logic [6:0]                  ch_work;
  logic [AW-1:0]               ch_idx;
  logic                        s_accept;
  logic                        ram_we;
  entry_t                      ram_rdata;
  entry_t                      ram_wdata;
  entry_t                      entry;

  logic signed [STATE_W-1:0]   rd_one;
  logic signed [STATE_W-1:0]   rd_two;
  logic signed [SAMPLE_W-1:0]  rd_prev;
  logic signed [STATE_W:0]     band;
  logic [STATE_W:0]            mag_full;
  logic [COEF_W-1:0]           coef;

  logic signed [PROD_W-1:0]    prod;
  logic signed [MA_W-1:0]      psh;
  logic [31:0]                 inc;
  logic [COEF_W-1:0]           base;
  logic [32:0]                 gsum;
  logic [24:0]                 gsat;
  logic [24:0]                 gcl;

  logic signed [MA_W-1:0]      x_ext;
  logic signed [MA_W-1:0]      prev_ext;
  logic signed [MA_W-1:0]      one_ext;
  logic signed [MA_W-1:0]      two_ext;
  logic signed [MA_W-1:0]      tgt1;
  logic signed [MA_W-1:0]      diff1;
  logic signed [MA_W-1:0]      one_sum;
  logic signed [STATE_W-1:0]   new_one;
  logic signed [STATE_W:0]     avg_sum;
  logic signed [STATE_W-1:0]   tgt2;
  logic signed [MA_W-1:0]      diff2;
  logic signed [MA_W-1:0]      two_sum;
  logic signed [STATE_W-1:0]   new_two;
  logic signed [25:0]          y_wide;
  logic [SAMPLE_W-1:0]         y_sat;
  logic                        out_free;

  // channel index wraps modulo the channel count
  always_comb begin
    ch_work = 7'(s_tdata_i[CH_W-1:0]);
    for (int i = 0; i < 8; i++) begin
      if (ch_work >= 7'(CHANNELS)) begin
        ch_work = ch_work - 7'(CHANNELS);
      end
    end
    ch_idx = ch_work[AW-1:0];
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign s_accept   = s_tvalid_i && s_tready_o;
  assign out_free   = !m_tvalid_q || m_tready_i;
  assign ram_we     = (state_q == ST_DONE) && out_free;

  dsf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ch_q),
    .wdata_i (ram_wdata),
    .re_i    (s_accept),
    .raddr_i (ch_idx),
    .rdata_o (ram_rdata)
  );

  // read side: entries never written since reset or clear read as zero
  assign entry    = valid_q[ch_q] ? ram_rdata : '0;
  assign rd_one   = entry[STATE_W-1:0];
  assign rd_two   = entry[2*STATE_W-1:STATE_W];
  assign rd_prev  = entry[ENTRY_W-1:2*STATE_W];
  assign band     = {rd_one[STATE_W-1], rd_one} - {rd_two[STATE_W-1], rd_two};
  assign mag_full = band[STATE_W] ? ((STATE_W+1)'(0) - band) : band;
  assign coef     = (mode_q == MODE_EFFICIENT) ? gain_slope_q : sensitivity_q;

  // shared multiplier and floored q.24 view of its registered product
  assign prod = ma_q * mb_q;
  assign psh  = p_q[57:24];
  assign inc  = p_q[56:25];

  // gain or cutoff: base plus increment, saturated at unity
  assign base = (mode_q == MODE_EFFICIENT) ? base_gain_q : base_cutoff_q;
  assign gsum = 33'(base) + 33'(inc);
  assign gsat = (gsum > 33'(ONE_Q24)) ? ONE_Q24 : gsum[24:0];
  assign gcl  = psh[MA_W-1] ? 25'd0 :
                ((psh > MA_W'(ONE_Q24)) ? ONE_Q24 : psh[24:0]);

  // stage one
  assign x_ext    = MA_W'(x_q);
  assign prev_ext = MA_W'(prev_q);
  assign one_ext  = MA_W'(one_q);
  assign two_ext  = MA_W'(two_q);
  assign tgt1     = (mode_q == MODE_EFFICIENT) ? (x_ext <<< 6) : ((x_ext + prev_ext) <<< 5);
  assign diff1    = tgt1 - one_ext;
  assign one_sum  = one_ext + psh;
  assign new_one  = one_sum[STATE_W-1:0];

  // stage two
  assign avg_sum  = {new_one[STATE_W-1], new_one} + {one_q[STATE_W-1], one_q};
  assign tgt2     = (mode_q == MODE_EFFICIENT) ? new_one : avg_sum[STATE_W:1];
  assign diff2    = MA_W'(tgt2) - two_ext;
  assign two_sum  = two_ext + psh;
  assign new_two  = two_sum[STATE_W-1:0];

  // output saturation to q1.23
  assign y_wide = new_two[STATE_W-1:6];
  always_comb begin
    if ((y_wide[25:23] == 3'b000) || (y_wide[25:23] == 3'b111)) begin
      y_sat = y_wide[SAMPLE_W-1:0];
    end else if (y_wide[25]) begin
      y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  assign ram_wdata = {((mode_q == MODE_EFFICIENT) ? prev_q : x_q), new_two, new_one_q};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_ACCURATE;
      base_cutoff_q <= RST_BASE_CUTOFF;
      sensitivity_q <= RST_SENSITIVITY;
      base_gain_q   <= RST_BASE_GAIN;
      gain_slope_q  <= RST_GAIN_SLOPE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODE:        mode_q        <= cfg_wdata_i[0];
        CFG_BASE_CUTOFF: base_cutoff_q <= cfg_wdata_i;
        CFG_SENSITIVITY: sensitivity_q <= cfg_wdata_i;
        CFG_BASE_GAIN:   base_gain_q   <= cfg_wdata_i;
        CFG_GAIN_SLOPE:  gain_slope_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer, valid flags and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      valid_q    <= '0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
      ma_q       <= '0;
      mb_q       <= '0;
      new_one_q  <= '0;
    end else begin
      if (ram_we) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            if (s_tuser_i == OP_CLEAR) begin
              valid_q <= '0;
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          ma_q    <= MA_W'(mag_full[STATE_W-1:0]);
          mb_q    <= MB_W'(coef);
          state_q <= ST_MUL_INC;
        end
        ST_MUL_INC: begin
          state_q <= ST_POST_INC;
        end
        ST_POST_INC: begin
          mb_q <= MB_W'(gsat);
          if (mode_q == MODE_EFFICIENT) begin
            ma_q    <= diff1;
            state_q <= ST_MUL_ONE;
          end else begin
            ma_q    <= CUBIC_C3;
            state_q <= ST_MUL_C3;
          end
        end
        ST_MUL_C3: begin
          state_q <= ST_POST_C3;
        end
        ST_POST_C3: begin
          ma_q    <= psh + CUBIC_C2;
          state_q <= ST_MUL_C2;
        end
        ST_MUL_C2: begin
          state_q <= ST_POST_C2;
        end
        ST_POST_C2: begin
          ma_q    <= psh + CUBIC_C1;
          state_q <= ST_MUL_C1;
        end
        ST_MUL_C1: begin
          state_q <= ST_POST_C1;
        end
        ST_POST_C1: begin
          ma_q    <= diff1;
          mb_q    <= MB_W'(gcl);
          state_q <= ST_MUL_ONE;
        end
        ST_MUL_ONE: begin
          state_q <= ST_POST_ONE;
        end
        ST_POST_ONE: begin
          new_one_q <= new_one;
          ma_q      <= diff2;
          state_q   <= ST_MUL_TWO;
        end
        ST_MUL_TWO: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            valid_q[ch_q] <= 1'b1;
            m_tdata_q     <= y_sat;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      ch_q <= ch_idx;
      x_q  <= s_tdata_i[CH_W+SAMPLE_W-1:CH_W];
    end
    if (state_q == ST_READ) begin
      one_q  <= rd_one;
      two_q  <= rd_two;
      prev_q <= rd_prev;
    end
    p_q <= prod;
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;

`ifndef SYNTHESIS
  // a clear leaves every channel empty and returns straight to idle
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && (s_tuser_i == OP_CLEAR) |=> (valid_q == '0) && (state_q == ST_IDLE))
    else $error("clear did not empty channel state");

  // a pending result is never overwritten by the next write-back
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && m_tvalid_o && !m_tready_i |=> (state_q == ST_DONE))
    else $error("result register overwritten");

  // a written channel is marked valid afterwards
  a_write_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> valid_q[$past(ch_q)])
    else $error("written channel not marked valid");

  // the gain applied to the stage updates never exceeds unity
  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_ONE) |-> (mb_q >= 0) && (mb_q <= MB_W'(ONE_Q24)))
    else $error("stage gain above unity");
`endif

endmodule
